[rtl/core/flash_word_write_combiner_assert.svh]
// Assertion macros for the flash word write combiner RTL.
`ifndef FLASH_WORD_WRITE_COMBINER_ASSERT_SVH
`define FLASH_WORD_WRITE_COMBINER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FWC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FWC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/fwc_pkg.sv]
// Shared constants, codes and types of the flash word write combiner.
package fwc_pkg;

  localparam int WORD_BYTES      = 32;
  localparam int SECTOR_COUNT    = 8;
  localparam int SECTOR_BYTES    = 4096;
  localparam int FLASH_BYTES     = SECTOR_COUNT * SECTOR_BYTES;

  localparam int CMD_W           = 2;
  localparam int ADDR_W          = 15;
  localparam int DATA_W          = 8;
  localparam int SECTOR_W        = 3;
  localparam int STATUS_W        = 2;
  localparam int CNT_W           = 32;
  localparam int PEND_W          = 5;
  localparam int PENDING_MAX     = 31;

  localparam int POS_W           = $clog2(WORD_BYTES);
  localparam int ROW_W           = ADDR_W - POS_W;
  localparam int ROWS            = FLASH_BYTES / WORD_BYTES;
  localparam int ROWS_PER_SECTOR = SECTOR_BYTES / WORD_BYTES;
  localparam int SWEEP_W         = $clog2(ROWS_PER_SECTOR);
  localparam int SECT_IDX_W      = $clog2(SECTOR_COUNT);
  localparam int LINE_W          = WORD_BYTES * DATA_W;

  localparam int QDEPTH          = 2;
  localparam int QPTR_W          = $clog2(QDEPTH);
  localparam int QCNT_W          = $clog2(QDEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ERASE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RD_COUNT = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_BLANK = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

  localparam logic [DATA_W-1:0] BLANK_BYTE = 8'hFF;

  // Work class decided by the front end.
  typedef enum logic [2:0] {
    OP_BUF,     // byte only lands in the word buffer
    OP_PROG,    // byte completes a word: blank check and program
    OP_ERASE,
    OP_RDBYTE,
    OP_RDCNT,
    OP_RANGE    // address or sector out of range
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [ROW_W-1:0]      row;
    logic [POS_W-1:0]      pos;
    logic [DATA_W-1:0]     data;
    logic [SECTOR_W-1:0]   sector;
    logic                  last;
  } op_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [DATA_W-1:0]     read_data;
    logic [CNT_W-1:0]      erase_count;
    logic [PEND_W-1:0]     pending;
    logic                  written;
    logic                  call_done;
  } res_t;

  typedef struct packed {
    logic clearing;  // power-up clearing pass in progress
    logic busy;      // multi-cycle operation in progress
  } back_stat_t;

endpackage

[rtl/core/fwc_front.sv]
// Front end: accepts transactions and classifies them into work items.
module fwc_front
  import fwc_pkg::*;
(
  input  logic                push,
  output logic                full,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [ADDR_W-1:0]   in_addr,
  input  logic [DATA_W-1:0]   in_data,
  input  logic [SECTOR_W-1:0] in_sector,
  input  logic                in_last_of_call,
  input  logic                q_full,
  input  back_stat_t          back_stat,
  output logic                q_push,
  output op_t                 q_op
);

  logic addr_bad;
  logic sector_bad;
  logic word_end;

  assign addr_bad   = {1'b0, in_addr} >= (ADDR_W+1)'(FLASH_BYTES);
  assign sector_bad = {1'b0, in_sector} >= (SECTOR_W+1)'(SECTOR_COUNT);
  assign word_end   = in_addr[POS_W-1:0] == POS_W'(WORD_BYTES - 1);

  assign full   = q_full || back_stat.clearing;
  assign q_push = push && !full;

  always_comb begin
    q_op.row    = in_addr[ADDR_W-1:POS_W];
    q_op.pos    = in_addr[POS_W-1:0];
    q_op.data   = in_data;
    q_op.sector = in_sector;
    q_op.last   = in_last_of_call;
    case (in_command)
      CMD_WRITE:    q_op.kind = addr_bad ? OP_RANGE : (word_end ? OP_PROG : OP_BUF);
      CMD_ERASE:    q_op.kind = sector_bad ? OP_RANGE : OP_ERASE;
      CMD_READ:     q_op.kind = addr_bad ? OP_RANGE : OP_RDBYTE;
      CMD_RD_COUNT: q_op.kind = sector_bad ? OP_RANGE : OP_RDCNT;
      default:      q_op.kind = OP_RANGE;
    endcase
  end

endmodule

[rtl/core/fwc_queue.sv]
// Short work queue between the front end and the back end.
module fwc_queue
  import fwc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output op_t  head_op,
  output logic head_valid,
  output logic q_full
);

  op_t               slots_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_pop;

  assign head_valid = count_r != '0;
  assign q_full     = count_r == QCNT_W'(QDEPTH);
  assign head_op    = slots_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

[rtl/core/fwc_back.sv]
// Back end: flash array, word buffer, erase counters and result register.
module fwc_back
  import fwc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  op_t        head_op,
  input  logic       head_valid,
  output logic       q_pop,
  output back_stat_t back_stat,
  output logic       res_valid,
  output res_t       res,
  input  logic       res_pop
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_ERASE
  } state_t;

  state_t             state_r, state_nxt;
  logic [ROW_W-1:0]   clr_row_r, clr_row_nxt;
  logic [SWEEP_W-1:0] sweep_r, sweep_nxt;
  op_t                cur_r, cur_nxt;
  logic [PEND_W-1:0]  pending_r, pending_nxt;
  logic [CNT_W-1:0]   counts_r [SECTOR_COUNT];
  logic [CNT_W-1:0]   counts_nxt [SECTOR_COUNT];
  logic               res_valid_r, res_valid_nxt;
  res_t               res_r, res_nxt;

  logic [DATA_W-1:0]  buf_r [WORD_BYTES];
  logic               buf_we;

  logic [LINE_W-1:0]  mem [ROWS];
  logic [LINE_W-1:0]  mem_rdata_r;
  logic [ROW_W-1:0]   mem_raddr;
  logic [ROW_W-1:0]   mem_waddr;
  logic [LINE_W-1:0]  mem_wdata;
  logic               mem_we;
  logic [LINE_W-1:0]  buf_line;
  logic               slot_free;

  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign slot_free = !res_valid_r || res_pop;
  assign back_stat.clearing = state_r == S_CLEAR;
  assign back_stat.busy     = state_r == S_READ || state_r == S_ERASE;
  assign mem_raddr = head_op.row;

  always_comb begin
    for (int i = 0; i < WORD_BYTES; i++) begin
      buf_line[i*DATA_W +: DATA_W] = buf_r[i];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_row_nxt   = clr_row_r;
    sweep_nxt     = sweep_r;
    cur_nxt       = cur_r;
    pending_nxt   = pending_r;
    counts_nxt    = counts_r;
    res_valid_nxt = res_valid_r && !res_pop;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    buf_we        = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = clr_row_r;
    mem_wdata     = {LINE_W{1'b1}};
    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        clr_row_nxt = clr_row_r + 1'b1;
        if (clr_row_r == ROW_W'(ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head_valid && slot_free) begin
          q_pop   = 1'b1;
          cur_nxt = head_op;
          case (head_op.kind)
            OP_BUF: begin
              buf_we      = 1'b1;
              pending_nxt = (pending_r == PEND_W'(PENDING_MAX)) ?
                            pending_r : pending_r + 1'b1;
              res_valid_nxt = 1'b1;
              res_nxt = '{status: ST_OK, read_data: '0, erase_count: '0,
                          pending: pending_nxt, written: 1'b0,
                          call_done: head_op.last};
            end
            OP_PROG: begin
              buf_we    = 1'b1;
              state_nxt = S_READ;
            end
            OP_RDBYTE: begin
              state_nxt = S_READ;
            end
            OP_ERASE: begin
              sweep_nxt = '0;
              state_nxt = S_ERASE;
            end
            OP_RDCNT: begin
              res_valid_nxt = 1'b1;
              res_nxt = '{status: ST_OK, read_data: '0,
                          erase_count: counts_r[head_op.sector[SECT_IDX_W-1:0]],
                          pending: pending_r, written: 1'b0,
                          call_done: head_op.last};
            end
            default: begin
              res_valid_nxt = 1'b1;
              res_nxt = '{status: ST_RANGE, read_data: '0, erase_count: '0,
                          pending: pending_r, written: 1'b0,
                          call_done: head_op.last};
            end
          endcase
        end
      end
      S_READ: begin
        state_nxt     = S_IDLE;
        res_valid_nxt = 1'b1;
        if (cur_r.kind == OP_RDBYTE) begin
          res_nxt = '{status: ST_OK,
                      read_data: mem_rdata_r[{cur_r.pos, 3'b000} +: DATA_W],
                      erase_count: '0, pending: pending_r, written: 1'b0,
                      call_done: cur_r.last};
        end else if (&mem_rdata_r) begin
          mem_we      = 1'b1;
          mem_waddr   = cur_r.row;
          mem_wdata   = buf_line;
          pending_nxt = '0;
          res_nxt = '{status: ST_OK, read_data: '0, erase_count: '0,
                      pending: '0, written: 1'b1, call_done: cur_r.last};
        end else begin
          res_nxt = '{status: ST_NOT_BLANK, read_data: '0, erase_count: '0,
                      pending: pending_r, written: 1'b0, call_done: cur_r.last};
        end
      end
      S_ERASE: begin
        mem_we    = 1'b1;
        mem_waddr = {cur_r.sector[SECT_IDX_W-1:0], sweep_r};
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == SWEEP_W'(ROWS_PER_SECTOR - 1)) begin
          counts_nxt[cur_r.sector[SECT_IDX_W-1:0]] =
            counts_r[cur_r.sector[SECT_IDX_W-1:0]] + 1'b1;
          state_nxt     = S_IDLE;
          res_valid_nxt = 1'b1;
          res_nxt = '{status: ST_OK, read_data: '0, erase_count: '0,
                      pending: pending_r, written: 1'b0, call_done: cur_r.last};
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_row_r   <= '0;
      sweep_r     <= '0;
      pending_r   <= '0;
      res_valid_r <= 1'b0;
      for (int i = 0; i < SECTOR_COUNT; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      sweep_r     <= sweep_nxt;
      pending_r   <= pending_nxt;
      res_valid_r <= res_valid_nxt;
      counts_r    <= counts_nxt;
    end
    cur_r <= cur_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_r[head_op.pos] <= head_op.data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    mem_rdata_r <= mem[mem_raddr];
  end

endmodule

[rtl/core/flash_word_write_combiner.sv]
// Top level: emulated NOR flash behind a write-combining word buffer.
// Sequence: buffer-only writes, range errors and count queries give their result from the idle state,
//   reads and word programs pass through a read state, and a sector erase sweeps one row a cycle.
// Throughput: one transaction per cycle for buffer-only writes while each result is popped; no new
//   work is taken during a read, word program or erase sweep; set by the single back end.
// Reset: synchronous active-low rst_n; then a clearing pass blanks the flash array one row
//   a cycle, with full held high; erase counters and pending count start at 0.
module flash_word_write_combiner
  import fwc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input queue side
  input  logic                push,
  output logic                full,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [ADDR_W-1:0]   in_addr,
  input  logic [DATA_W-1:0]   in_data,
  input  logic [SECTOR_W-1:0] in_sector,
  input  logic                in_last_of_call,
  // result queue side
  output logic                empty,
  input  logic                pop,
  output logic [STATUS_W-1:0] out_status,
  output logic [DATA_W-1:0]   out_read_data,
  output logic [CNT_W-1:0]    out_erase_count,
  output logic [PEND_W-1:0]   out_pending_bytes,
  output logic                out_word_written,
  output logic                out_call_done
);

`include "flash_word_write_combiner_assert.svh"

  // Front end to queue
  logic       q_push;
  op_t        q_op;
  logic       q_full;

  // Queue to back end
  op_t        head_op;
  logic       head_valid;
  logic       q_pop;

  // Back end status and result slot
  back_stat_t back_stat;
  logic       res_valid;
  res_t       res;

  // Classify the incoming transaction; hold off input during the clearing pass.
  fwc_front u_front (
    .push            (push),
    .full            (full),
    .in_command      (in_command),
    .in_addr         (in_addr),
    .in_data         (in_data),
    .in_sector       (in_sector),
    .in_last_of_call (in_last_of_call),
    .q_full          (q_full),
    .back_stat       (back_stat),
    .q_push          (q_push),
    .q_op            (q_op)
  );

  // Decouple acceptance from execution so the front keeps taking work while a
  // result waits or an erase sweeps.
  fwc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_op),
    .pop        (q_pop),
    .head_op    (head_op),
    .head_valid (head_valid),
    .q_full     (q_full)
  );

  // Execute: buffer the byte, blank check and program a completed word,
  // erase a sector, read back, answer count queries and range errors; drop the result into the output register.
  fwc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_op    (head_op),
    .head_valid (head_valid),
    .q_pop      (q_pop),
    .back_stat  (back_stat),
    .res_valid  (res_valid),
    .res        (res),
    .res_pop    (pop)
  );

  // Present the oldest result while it waits.
  assign empty             = !res_valid;
  assign out_status        = res.status;
  assign out_read_data     = res.read_data;
  assign out_erase_count   = res.erase_count;
  assign out_pending_bytes = res.pending;
  assign out_word_written  = res.written;
  assign out_call_done     = res.call_done;

  // No transaction may enter while the array is still being blanked.
  `FWC_ASSERT_IMP(a_clear_holds_input, back_stat.clearing, full, "input open during clearing pass")
  // A multi-cycle operation only starts with the result slot free and fills it at its end.
  `FWC_ASSERT_IMP(a_busy_slot_empty, back_stat.busy, empty, "result slot filled while back end busy")
  // A programmed word always empties the buffer count and reports success.
  `FWC_ASSERT_IMP(a_written_clears_pending, !empty && out_word_written, out_pending_bytes == '0 && out_status == ST_OK, "word written with pending bytes or error")
  // The clearing pass only ever follows reset.
  `FWC_ASSERT_NXT(a_no_clear_reentry, !back_stat.clearing, !back_stat.clearing, "clearing pass restarted")

endmodule
